>>> rtl/core/mctq_pkg.sv
// mctq_pkg: shared sizes, codes, descriptor type and index helpers
// for the multi-channel transmit ring queue; no dependencies
package mctq_pkg;

	localparam int DEPTH    = 128;
	localparam int CHANNELS = 3;
	localparam int IDX_W    = $clog2(DEPTH);
	localparam int SLOTS    = CHANNELS * DEPTH;
	localparam int ADDR_W   = $clog2(SLOTS);
	localparam int CSEL_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CH_W     = 2;
	localparam int ID_W     = 29;
	localparam int LEN_W    = 4;
	localparam int DATA_W   = 64;
	localparam int MARK_W   = 7;
	localparam int FILL_W   = 7;
	localparam int STAT_W   = 2;
	localparam int MAX_LEN  = 8;

	localparam logic OP_ENQ    = 1'b0;
	localparam logic OP_TXDONE = 1'b1;

	localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
	localparam logic [STAT_W-1:0] ST_LEN_REJ = 2'd1;
	localparam logic [STAT_W-1:0] ST_BAD_CH  = 2'd2;

	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [CSEL_W-1:0] csel_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic              dropped;
		logic [FILL_W-1:0] fill;
		logic              send;
		logic [CH_W-1:0]   ch;
		logic [MARK_W-1:0] marker;
		logic              wr_en;
		addr_t             wr_addr;
		logic [ID_W-1:0]   id;
		logic [LEN_W-1:0]  len;
		logic [DATA_W-1:0] payload;
		addr_t             rd_addr;
		logic              fwd;
	} desc_t;

	function automatic idx_t idx_adv(idx_t i);
		return (i == idx_t'(DEPTH - 1)) ? '0 : i + idx_t'(1);
	endfunction

	function automatic idx_t idx_level(idx_t w, idx_t r);
		return (w >= r) ? idx_t'(w - r) : idx_t'(DEPTH - int'(r) + int'(w));
	endfunction

	function automatic addr_t slot_addr(csel_t s, idx_t i);
		return addr_t'(s) * addr_t'(DEPTH) + addr_t'(i);
	endfunction

endpackage

>>> rtl/core/mctq_front.sv
// mctq_front: accepts items, checks them, keeps per-channel ring indices
// and emits one descriptor per item; depends on mctq_pkg
module mctq_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  logic                          op,
	input  logic [mctq_pkg::CH_W-1:0]     channel,
	input  logic [mctq_pkg::ID_W-1:0]     frame_id,
	input  logic [mctq_pkg::LEN_W-1:0]    frame_len,
	input  logic [mctq_pkg::DATA_W-1:0]   payload,
	input  logic                          hw_fifo_has_space,
	output logic                          push_valid,
	input  logic                          push_ready,
	output mctq_pkg::desc_t               push_desc
);

	mctq_pkg::idx_t wr_idx_q [mctq_pkg::CHANNELS];
	mctq_pkg::idx_t rd_idx_q [mctq_pkg::CHANNELS];

	logic                            chan_ok;
	logic                            len_bad;
	logic                            do_ok;
	logic                            enq;
	logic                            full;
	logic                            send;
	mctq_pkg::csel_t                 sel;
	mctq_pkg::idx_t                  w0;
	mctq_pkg::idx_t                  r0;
	mctq_pkg::idx_t                  r1;
	mctq_pkg::idx_t                  w1;
	mctq_pkg::idx_t                  r2;
	logic [mctq_pkg::STAT_W-1:0]     status_c;

	assign chan_ok = 32'(channel) < mctq_pkg::CHANNELS;
	assign len_bad = (op == mctq_pkg::OP_ENQ) && (32'(frame_len) > mctq_pkg::MAX_LEN);
	assign sel     = chan_ok ? mctq_pkg::csel_t'(channel) : '0;
	assign w0      = wr_idx_q[sel];
	assign r0      = rd_idx_q[sel];

	always_comb begin
		if (len_bad) begin
			status_c = mctq_pkg::ST_LEN_REJ;
		end else if (!chan_ok) begin
			status_c = mctq_pkg::ST_BAD_CH;
		end else begin
			status_c = mctq_pkg::ST_OK;
		end
	end

	assign do_ok = (status_c == mctq_pkg::ST_OK);
	assign enq   = do_ok && (op == mctq_pkg::OP_ENQ);
	assign full  = 32'(mctq_pkg::idx_level(w0, r0)) >= (mctq_pkg::DEPTH - 1);
	assign r1    = (enq && full) ? mctq_pkg::idx_adv(r0) : r0;
	assign w1    = enq ? mctq_pkg::idx_adv(w0) : w0;
	assign send  = do_ok && (r1 != w1) && hw_fifo_has_space;
	assign r2    = send ? mctq_pkg::idx_adv(r1) : r1;

	assign req_ready  = push_ready;
	assign push_valid = req_valid;

	always_comb begin
		push_desc         = '0;
		push_desc.status  = status_c;
		push_desc.dropped = enq && full;
		push_desc.fill    = chan_ok ?
			mctq_pkg::FILL_W'(mctq_pkg::idx_level(w1, r2)) : '0;
		push_desc.send    = send;
		push_desc.ch      = send ? channel : '0;
		push_desc.marker  = send ? mctq_pkg::MARK_W'(r1) : '0;
		push_desc.wr_en   = enq;
		push_desc.wr_addr = mctq_pkg::slot_addr(sel, w0);
		push_desc.id      = frame_id;
		push_desc.len     = frame_len;
		push_desc.payload = payload;
		push_desc.rd_addr = mctq_pkg::slot_addr(sel, r1);
		push_desc.fwd     = enq && (r1 == w0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < mctq_pkg::CHANNELS; i++) begin
				wr_idx_q[i] <= '0;
				rd_idx_q[i] <= '0;
			end
		end else if (req_valid && req_ready && chan_ok) begin
			wr_idx_q[sel] <= w1;
			rd_idx_q[sel] <= r2;
		end
	end

endmodule

>>> rtl/core/mctq_fifo.sv
// mctq_fifo: two-entry descriptor queue between front and back
// depends on mctq_pkg
module mctq_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  mctq_pkg::desc_t push_desc,
	output logic            pop_valid,
	input  logic            pop_ready,
	output mctq_pkg::desc_t pop_desc
);

	mctq_pkg::desc_t entry_q [2];
	logic            wptr_q;
	logic            rptr_q;
	logic [1:0]      count_q;
	logic            push;
	logic            pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_desc   = entry_q[rptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wptr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (pop) begin
				rptr_q <= ~rptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

>>> rtl/core/mctq_back.sv
// mctq_back: frame store, slot write and head read, result register
// depends on mctq_pkg
module mctq_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          pop_valid,
	output logic                          pop_ready,
	input  mctq_pkg::desc_t               pop_desc,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output logic [mctq_pkg::STAT_W-1:0]   status,
	output logic                          frame_valid,
	output logic [mctq_pkg::CH_W-1:0]     frame_channel,
	output logic [mctq_pkg::ID_W-1:0]     out_id,
	output logic [mctq_pkg::LEN_W-1:0]    out_len,
	output logic [mctq_pkg::DATA_W-1:0]   out_payload,
	output logic [mctq_pkg::MARK_W-1:0]   marker,
	output logic                          dropped_oldest,
	output logic [mctq_pkg::FILL_W-1:0]   fill_level
);

	localparam int IDLEN_W = mctq_pkg::ID_W + mctq_pkg::LEN_W;

	logic [IDLEN_W-1:0]             id_len_mem_q  [mctq_pkg::SLOTS];
	logic [mctq_pkg::DATA_W-1:0]    payload_mem_q [mctq_pkg::SLOTS];

	logic                           v_s1;
	mctq_pkg::desc_t                d_s1;
	logic [IDLEN_W-1:0]             rd_id_len_s1;
	logic [mctq_pkg::DATA_W-1:0]    rd_payload_s1;
	logic                           adv_s1;
	logic                           take;

	logic                           rsp_valid_q;
	logic [mctq_pkg::STAT_W-1:0]    status_q;
	logic                           frame_valid_q;
	logic [mctq_pkg::CH_W-1:0]      frame_channel_q;
	logic [mctq_pkg::ID_W-1:0]      out_id_q;
	logic [mctq_pkg::LEN_W-1:0]     out_len_q;
	logic [mctq_pkg::DATA_W-1:0]    out_payload_q;
	logic [mctq_pkg::MARK_W-1:0]    marker_q;
	logic                           dropped_q;
	logic [mctq_pkg::FILL_W-1:0]    fill_q;

	assign adv_s1    = v_s1 && (!rsp_valid_q || rsp_ready);
	assign pop_ready = !v_s1 || adv_s1;
	assign take      = pop_valid && pop_ready;

	// slot write and head read in the same cycle; same-slot reads use fwd
	always_ff @(posedge clk) begin
		if (take) begin
			if (pop_desc.wr_en) begin
				id_len_mem_q[pop_desc.wr_addr]  <= {pop_desc.len, pop_desc.id};
				payload_mem_q[pop_desc.wr_addr] <= pop_desc.payload;
			end
			rd_id_len_s1  <= id_len_mem_q[pop_desc.rd_addr];
			rd_payload_s1 <= payload_mem_q[pop_desc.rd_addr];
			d_s1          <= pop_desc;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			status_q        <= d_s1.status;
			frame_valid_q   <= d_s1.send;
			frame_channel_q <= d_s1.ch;
			marker_q        <= d_s1.marker;
			dropped_q       <= d_s1.dropped;
			fill_q          <= d_s1.fill;
			if (!d_s1.send) begin
				out_id_q      <= '0;
				out_len_q     <= '0;
				out_payload_q <= '0;
			end else if (d_s1.fwd) begin
				out_id_q      <= d_s1.id;
				out_len_q     <= d_s1.len;
				out_payload_q <= d_s1.payload;
			end else begin
				out_id_q      <= rd_id_len_s1[mctq_pkg::ID_W-1:0];
				out_len_q     <= rd_id_len_s1[IDLEN_W-1:mctq_pkg::ID_W];
				out_payload_q <= rd_payload_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (take) begin
				v_s1 <= 1'b1;
			end else if (adv_s1) begin
				v_s1 <= 1'b0;
			end
			if (adv_s1) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid      = rsp_valid_q;
	assign status         = status_q;
	assign frame_valid    = frame_valid_q;
	assign frame_channel  = frame_channel_q;
	assign out_id         = out_id_q;
	assign out_len        = out_len_q;
	assign out_payload    = out_payload_q;
	assign marker         = marker_q;
	assign dropped_oldest = dropped_q;
	assign fill_level     = fill_q;

endmodule

>>> rtl/core/multi_channel_tx_ring_queue_top.sv
// multi_channel_tx_ring_queue_top: top level of the transmit ring queue
// depends on mctq_pkg, mctq_front, mctq_fifo, mctq_back
//
// Three transmit rings of 128 slots each (up to 127 frames per ring), one
// result per accepted request. The front checks length and channel, updates
// the ring indices and hands a descriptor through a two-entry queue to the
// back, which writes the frame store and reads the head slot from two
// single-port-write, single-port-read memories of 384 entries each. A result
// passes the queue, s1 and result registers, and a new request can be taken
// every cycle while the queue has room; the memory port pair sets that rate.
// The store needs no clearing after reset and requests are taken right away.
module multi_channel_tx_ring_queue_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  logic                          op,
	input  logic [mctq_pkg::CH_W-1:0]     channel,
	input  logic [mctq_pkg::ID_W-1:0]     frame_id,
	input  logic [mctq_pkg::LEN_W-1:0]    frame_len,
	input  logic [mctq_pkg::DATA_W-1:0]   payload,
	input  logic                          hw_fifo_has_space,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output logic [mctq_pkg::STAT_W-1:0]   status,
	output logic                          frame_valid,
	output logic [mctq_pkg::CH_W-1:0]     frame_channel,
	output logic [mctq_pkg::ID_W-1:0]     out_id,
	output logic [mctq_pkg::LEN_W-1:0]    out_len,
	output logic [mctq_pkg::DATA_W-1:0]   out_payload,
	output logic [mctq_pkg::MARK_W-1:0]   marker,
	output logic                          dropped_oldest,
	output logic [mctq_pkg::FILL_W-1:0]   fill_level
);

	logic            push_valid;
	logic            push_ready;
	mctq_pkg::desc_t push_desc;
	logic            pop_valid;
	logic            pop_ready;
	mctq_pkg::desc_t pop_desc;

	mctq_front u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.req_valid         (req_valid),
		.req_ready         (req_ready),
		.op                (op),
		.channel           (channel),
		.frame_id          (frame_id),
		.frame_len         (frame_len),
		.payload           (payload),
		.hw_fifo_has_space (hw_fifo_has_space),
		.push_valid        (push_valid),
		.push_ready        (push_ready),
		.push_desc         (push_desc)
	);

	mctq_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_desc  (push_desc),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_desc   (pop_desc)
	);

	mctq_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.pop_valid      (pop_valid),
		.pop_ready      (pop_ready),
		.pop_desc       (pop_desc),
		.rsp_valid      (rsp_valid),
		.rsp_ready      (rsp_ready),
		.status         (status),
		.frame_valid    (frame_valid),
		.frame_channel  (frame_channel),
		.out_id         (out_id),
		.out_len        (out_len),
		.out_payload    (out_payload),
		.marker         (marker),
		.dropped_oldest (dropped_oldest),
		.fill_level     (fill_level)
	);

endmodule
